[sv/sorted_priority_deque_macros.svh]
// assertion macros used by the sorted priority deque controller
// expects clk and rst_n in the scope of each use
`ifndef SORTED_PRIORITY_DEQUE_MACROS_SVH
`define SORTED_PRIORITY_DEQUE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/spd_pkg.sv]
// shared types and constants for the sorted priority deque
// no dependencies
package spd_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_BITS = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_SORTED     = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] new_key;
        logic [15:0] new_tag;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_key;
        logic [15:0] out_tag;
        logic [6:0]  entry_count;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT_FRONT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [IDX_W-1:0]    pos;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } cell_ctl_t;

endpackage

[sv/spd_cell.sv]
// one slot of the shifting list: holds a key and tag, compares against the broadcast key
// depends on spd_pkg
module spd_cell
    import spd_pkg::*;
(
    input  logic                clk,
    input  logic [IDX_W-1:0]    idx,
    input  cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [TAG_BITS-1:0] left_tag,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [TAG_BITS-1:0] right_tag,
    output logic [KEY_BITS-1:0] key,
    output logic [TAG_BITS-1:0] tag,
    output logic                ge
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                // slots behind the insertion point move one place back
                if (idx > ctl.pos)
                begin
                    key_next = left_key;
                    tag_next = left_tag;
                end
                else if (idx == ctl.pos)
                begin
                    key_next = ctl.key;
                    tag_next = ctl.tag;
                end
            end
            OP_SHIFT_FRONT:
            begin
                key_next = right_key;
                tag_next = right_tag;
            end
            default:
            begin
                key_next = key_reg;
                tag_next = tag_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;
    assign ge  = (key_reg >= ctl.key);

endmodule

[sv/spd_ctrl.sv]
// command sequencer: accepts commands, finds the insertion point, drives the cells,
// holds the entry count and the result register; depends on spd_pkg and the macros header
`include "sorted_priority_deque_macros.svh"

module spd_ctrl
    import spd_pkg::*;
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  in_item_t                            in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output out_item_t                           out_data,
    input  logic [CAPACITY-1:0][KEY_BITS-1:0]   cell_key,
    input  logic [CAPACITY-1:0][TAG_BITS-1:0]   cell_tag,
    input  logic [CAPACITY-1:0]                 cell_ge,
    output cell_ctl_t                           cell_ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_POS,
        S_APPLY
    } state_t;

    function automatic logic [IDX_W-1:0] onehot_idx(input logic [CAPACITY-1:0] oh);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = 0; i < CAPACITY; i++)
            if (oh[i])
                r = r | IDX_W'(i);
        return r;
    endfunction

    function automatic logic [CAPACITY-1:0] first_one(input logic [CAPACITY-1:0] x);
        return x & (~x + CAPACITY'(1));
    endfunction

    function automatic logic [CAPACITY-1:0] reverse(input logic [CAPACITY-1:0] x);
        logic [CAPACITY-1:0] r;
        for (int i = 0; i < CAPACITY; i++)
            r[i] = x[CAPACITY-1-i];
        return r;
    endfunction

    function automatic logic [KEY_BITS-1:0] pick_key(
        input logic [CAPACITY-1:0][KEY_BITS-1:0] arr,
        input logic [CAPACITY-1:0]               sel
    );
        logic [KEY_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < CAPACITY; i++)
            r = r | (arr[i] & {KEY_BITS{sel[i]}});
        return r;
    endfunction

    function automatic logic [TAG_BITS-1:0] pick_tag(
        input logic [CAPACITY-1:0][TAG_BITS-1:0] arr,
        input logic [CAPACITY-1:0]               sel
    );
        logic [TAG_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < CAPACITY; i++)
            r = r | (arr[i] & {TAG_BITS{sel[i]}});
        return r;
    endfunction

    state_t              state_reg, state_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] ge_reg, ge_next;
    logic [KEY_BITS-1:0] front_reg, front_next;
    logic [KEY_BITS-1:0] back_reg, back_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    logic [CAPACITY-1:0] valid_mask;
    logic [CAPACITY-1:0] back_oh;
    logic                accept;
    logic                fire;
    logic                is_full;
    logic                is_empty;
    cell_op_t            op;
    logic [KEY_BITS-1:0] diff_lo, diff_hi;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            valid_mask[i] = (CNT_W'(i) < count_reg);
            back_oh[i]    = (CNT_W'(i) == count_reg - CNT_W'(1));
        end
    end

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // the result register must be free before a command is applied
    assign fire     = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);
    assign diff_lo  = key_reg - front_reg;
    assign diff_hi  = back_reg - key_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        count_next     = count_reg;
        ge_next        = ge_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        pos_next       = pos_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        op             = OP_HOLD;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = in_data.command;
                    key_next = in_data.new_key[KEY_BITS-1:0];
                    tag_next = in_data.new_tag[TAG_BITS-1:0];
                    pos_next = (in_data.command == CMD_PUSH_BACK)
                             ? count_reg[IDX_W-1:0] : '0;
                    if (in_data.command == CMD_SORTED && !is_empty && !is_full)
                        state_next = S_CMP;
                    else
                        state_next = S_APPLY;
                end
            end
            S_CMP:
            begin
                ge_next    = cell_ge & valid_mask;
                front_next = cell_key[0];
                back_next  = pick_key(cell_key, back_oh);
                state_next = S_POS;
            end
            S_POS:
            begin
                if (ge_reg[0])
                    pos_next = '0;
                else if ((ge_reg & back_oh) == '0)
                    pos_next = count_reg[IDX_W-1:0];
                else if (diff_lo <= diff_hi)
                    pos_next = onehot_idx(first_one(ge_reg));
                else
                    // just after the last entry below the new key
                    pos_next = onehot_idx(reverse(first_one(reverse(valid_mask & ~ge_reg))))
                             + IDX_W'(1);
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (fire)
                begin
                    out_next.status  = ST_DONE;
                    out_next.out_key = '0;
                    out_next.out_tag = '0;
                    case (cmd_reg) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED:
                        begin
                            if (is_full)
                                out_next.status = ST_FULL;
                            else
                            begin
                                op         = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_empty)
                                out_next.status = ST_EMPTY;
                            else
                            begin
                                op               = OP_SHIFT_FRONT;
                                out_next.out_key = 16'(cell_key[0]);
                                out_next.out_tag = 16'(cell_tag[0]);
                                count_next       = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_empty)
                                out_next.status = ST_EMPTY;
                            else
                            begin
                                out_next.out_key = 16'(pick_key(cell_key, back_oh));
                                out_next.out_tag = 16'(pick_tag(cell_tag, back_oh));
                                count_next       = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_next.status = ST_DONE;
                        end
                    endcase
                    out_next.entry_count = 7'(count_next);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        tag_reg   <= tag_next;
        ge_reg    <= ge_next;
        front_reg <= front_next;
        back_reg  <= back_next;
        pos_reg   <= pos_next;
        out_reg   <= out_next;
    end

    assign cell_ctl.op  = op;
    assign cell_ctl.pos = pos_reg;
    assign cell_ctl.key = key_reg;
    assign cell_ctl.tag = tag_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SPD_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `SPD_ASSERT_NEXT(a_accept_busy, accept, state_reg != S_IDLE, "idle right after a transfer")
    `SPD_ASSERT_NOW(a_pos_range, state_reg == S_POS, !is_empty && !is_full, "position search on empty or full list")
    `SPD_ASSERT_NOW(a_full_count, out_valid_reg && out_reg.status == ST_FULL, out_reg.entry_count == 7'(CAPACITY), "full status with room left")
    `SPD_ASSERT_NOW(a_empty_result, out_valid_reg && out_reg.status == ST_EMPTY, out_reg.entry_count == '0 && out_reg.out_key == '0, "empty status with entries")

endmodule

[sv/sorted_priority_deque.sv]
// Sorted priority deque: a list of up to 64 (key, tag) entries held in a row of shifting
// cells, front at cell 0. Push front, push back, pop front, pop back and unused codes go
// from the idle state, where the command is taken, to the apply state, where every cell
// shifts or holds; a sorted insert into a list that is neither empty nor full adds a
// state in which all cells compare against the new key and one that encodes the insertion
// point. One result is returned per command; a new command is taken while the previous
// result still waits on the output. Slot contents are not cleared at reset.
// depends on spd_pkg, spd_cell and spd_ctrl
module sorted_priority_deque
    import spd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic [CAPACITY-1:0][KEY_BITS-1:0] cell_key;
    logic [CAPACITY-1:0][TAG_BITS-1:0] cell_tag;
    logic [CAPACITY-1:0]               cell_ge;
    cell_ctl_t                         cell_ctl;

    spd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cell_key  (cell_key),
        .cell_tag  (cell_tag),
        .cell_ge   (cell_ge),
        .cell_ctl  (cell_ctl)
    );

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            // the end cells see themselves as the missing neighbor
            localparam int LI = (i == 0) ? 0 : i - 1;
            localparam int RI = (i == CAPACITY - 1) ? i : i + 1;

            spd_cell u_cell (
                .clk       (clk),
                .idx       (IDX_W'(i)),
                .ctl       (cell_ctl),
                .left_key  (cell_key[LI]),
                .left_tag  (cell_tag[LI]),
                .right_key (cell_key[RI]),
                .right_tag (cell_tag[RI]),
                .key       (cell_key[i]),
                .tag       (cell_tag[i]),
                .ge        (cell_ge[i])
            );
        end
    endgenerate

endmodule

[dv/spd_order_checker.sv]
// prediction and comparison for the sorted priority deque: watches both channels,
// keeps its own copy of the list and checks each result in order
// depends on spd_pkg
module spd_order_checker
    import spd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    output int        fail_count,
    output int        outstanding,
    output int        results_seen,
    output int        full_refusals,
    output int        empty_pops,
    output int        peak_len
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] KEY_MASK = 16'((64'd1 << KEY_BITS) - 64'd1);

    logic [15:0] list_key [CAPACITY];
    logic [15:0] list_tag [CAPACITY];
    int          list_len;
    out_item_t   predicted_replies [$];
    out_item_t   head;

    // runs one command on the local list and returns the reply it should produce
    function automatic out_item_t run_list_command(in_item_t item);
        out_item_t   reply;
        logic [15:0] k;
        int          pos;
        int          i;
        reply = '0;
        reply.status = ST_DONE;
        k = item.new_key & KEY_MASK;
        pos = 0;
        case (item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED:
            begin
                if (list_len >= CAPACITY)
                begin
                    reply.status = ST_FULL;
                end
                else
                begin
                    if (item.command == CMD_PUSH_BACK)
                        pos = list_len;
                    else if (item.command == CMD_SORTED && list_len > 0)
                    begin
                        if (k <= list_key[0])
                            pos = 0;
                        else if (list_key[list_len-1] < k)
                            pos = list_len;
                        else if ((k - list_key[0]) <= (list_key[list_len-1] - k))
                        begin
                            // nearer the front: stop at first key not below the new one
                            pos = list_len;
                            for (i = 0; i < list_len; i++)
                                if (list_key[i] >= k)
                                begin
                                    pos = i;
                                    break;
                                end
                        end
                        else
                        begin
                            // nearer the back: go after the last key below the new one
                            pos = 0;
                            for (i = list_len; i > 0; i--)
                                if (list_key[i-1] < k)
                                begin
                                    pos = i;
                                    break;
                                end
                        end
                    end
                    for (i = list_len; i > pos; i--)
                    begin
                        list_key[i] = list_key[i-1];
                        list_tag[i] = list_tag[i-1];
                    end
                    list_key[pos] = k;
                    list_tag[pos] = item.new_tag;
                    list_len++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (list_len == 0)
                begin
                    reply.status = ST_EMPTY;
                end
                else
                begin
                    reply.out_key = list_key[0];
                    reply.out_tag = list_tag[0];
                    for (i = 1; i < list_len; i++)
                    begin
                        list_key[i-1] = list_key[i];
                        list_tag[i-1] = list_tag[i];
                    end
                    list_len--;
                end
            end
            CMD_POP_BACK:
            begin
                if (list_len == 0)
                begin
                    reply.status = ST_EMPTY;
                end
                else
                begin
                    reply.out_key = list_key[list_len-1];
                    reply.out_tag = list_tag[list_len-1];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        reply.entry_count = 7'(list_len);
        return reply;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            predicted_replies.delete();
            list_len      = 0;
            fail_count    = 0;
            outstanding   = 0;
            results_seen  = 0;
            full_refusals = 0;
            empty_pops    = 0;
            peak_len      = 0;
        end
        else
        begin
            // a result can never belong to a command taken on the same edge
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_replies.size() == 0)
                begin
                    $display("%0t: result with nothing pending: status %0d key %0h tag %0h count %0d",
                             $time, out_data.status, out_data.out_key, out_data.out_tag,
                             out_data.entry_count);
                    fail_count++;
                end
                else
                begin
                    head = predicted_replies.pop_front();
                    if (out_data.status !== head.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, head.status, out_data.status);
                        fail_count++;
                    end
                    if (out_data.out_key !== head.out_key)
                    begin
                        $display("%0t: out_key expected %0h got %0h",
                                 $time, head.out_key, out_data.out_key);
                        fail_count++;
                    end
                    if (out_data.out_tag !== head.out_tag)
                    begin
                        $display("%0t: out_tag expected %0h got %0h",
                                 $time, head.out_tag, out_data.out_tag);
                        fail_count++;
                    end
                    if (out_data.entry_count !== head.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, head.entry_count, out_data.entry_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                head = run_list_command(in_data);
                if (head.status == ST_FULL)
                    full_refusals++;
                if (head.status == ST_EMPTY)
                    empty_pops++;
                if (list_len > peak_len)
                    peak_len = list_len;
                predicted_replies.push_back(head);
            end
            outstanding = predicted_replies.size();
        end
    end

endmodule

[dv/tb.sv]
// top of the sorted priority deque testbench: clock, reset, command traffic,
// result back-pressure, watchdog and verdict
// depends on spd_pkg, sorted_priority_deque and spd_order_checker
module tb
    import spd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS     = 700;
    localparam int          STALL_LIMIT      = 2000;
    localparam int          HOLD_OFF_CYCLES  = 300;
    localparam logic [2:0]  FIRST_UNUSED_CMD = 3'd5;
    localparam logic [2:0]  LAST_UNUSED_CMD  = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      in_xfer;
    logic      calm;

    int fail_count;
    int outstanding;
    int results_seen;
    int full_refusals;
    int empty_pops;
    int peak_len;
    int sent;

    sorted_priority_deque u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    spd_order_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .full_refusals (full_refusals),
        .empty_pops    (empty_pops),
        .peak_len      (peak_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // remembers whether the last edge took a command, read back at the falling edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_xfer <= 1'b0;
        else
            in_xfer <= in_valid && in_ready;
    end

    // a window with no idling on either side
    assign calm = (results_seen >= 300) && (results_seen < 380);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_item_t make_cmd(logic [2:0] c, logic [15:0] k, logic [15:0] t);
        in_item_t item;
        item.command = c;
        item.new_key = k;
        item.new_tag = t;
        return item;
    endfunction

    function automatic in_item_t random_command(int insert_pct, bit narrow);
        in_item_t item;
        int       r;
        item.new_tag = 16'($urandom);
        r = $urandom_range(0, 99);
        if (narrow)
            item.new_key = 16'($urandom_range(0, 15));
        else if (r < 5)
            item.new_key = 16'h0000;
        else if (r < 10)
            item.new_key = 16'hffff;
        else
            item.new_key = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            item.command = 3'($urandom_range(FIRST_UNUSED_CMD, LAST_UNUSED_CMD));
        end
        else if ($urandom_range(0, 99) < insert_pct)
        begin
            r = $urandom_range(0, 9);
            item.command = (r < 6) ? CMD_SORTED : (r < 8) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end
        else
        begin
            item.command = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        return item;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic offer(input in_item_t item);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(negedge clk); while (!in_xfer);
        sent++;
    endtask

    // result side: random stalls, plus a long hold-off each time enough results passed
    initial
    begin
        int stall;
        int next_hold;
        stall = 0;
        next_hold = 150;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (results_seen >= next_hold)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                next_hold += 300;
            end
            else if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!calm)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("%0t: watchdog expired, no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sent_rand;
        int phase;
        int len;
        int insert_pct;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        sent      = 0;
        sent_rand = 0;
        phase     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // pops and unused codes on an empty list
        offer(make_cmd(CMD_POP_FRONT, 16'hffff, 16'hffff));
        offer(make_cmd(CMD_POP_BACK, 16'h1234, 16'h5678));
        offer(make_cmd(FIRST_UNUSED_CMD, 16'hffff, 16'hffff));
        offer(make_cmd(FIRST_UNUSED_CMD + 3'd1, 16'h0000, 16'hffff));
        offer(make_cmd(LAST_UNUSED_CMD, 16'hffff, 16'h0000));
        // sorted insert: empty, at front, at back, scan from front, scan from back
        offer(make_cmd(CMD_SORTED, 16'd100, 16'd1));
        offer(make_cmd(CMD_SORTED, 16'd50, 16'd2));
        offer(make_cmd(CMD_SORTED, 16'd1000, 16'd3));
        offer(make_cmd(CMD_SORTED, 16'd200, 16'd4));
        offer(make_cmd(CMD_SORTED, 16'd900, 16'd5));
        // duplicates of an inner key and of the back key
        offer(make_cmd(CMD_SORTED, 16'd100, 16'd6));
        offer(make_cmd(CMD_SORTED, 16'd1000, 16'd7));
        // break the ordering with the extreme keys, then insert into it
        offer(make_cmd(CMD_PUSH_FRONT, 16'hffff, 16'hffff));
        offer(make_cmd(CMD_PUSH_BACK, 16'h0000, 16'h0000));
        offer(make_cmd(CMD_SORTED, 16'h7fff, 16'haaaa));
        offer(make_cmd(CMD_SORTED, 16'h0001, 16'h5555));
        offer(make_cmd(CMD_SORTED, 16'h0005, 16'h0f0f));
        offer(make_cmd(CMD_POP_FRONT, 16'h0000, 16'h0000));
        offer(make_cmd(CMD_POP_BACK, 16'hffff, 16'hffff));
        offer(make_cmd(CMD_POP_FRONT, 16'h0000, 16'h0000));
        offer(make_cmd(CMD_SORTED, 16'h0000, 16'hffff));
        offer(make_cmd(CMD_POP_BACK, 16'h0000, 16'h0000));

        // phases lean toward filling, draining or a mix; the first one reaches full
        while (sent_rand < RANDOM_ITEMS)
        begin
            case (phase % 3)
                0:       insert_pct = 85;
                1:       insert_pct = 20;
                default: insert_pct = 55;
            endcase
            len = (phase % 3 == 0) ? 140 : $urandom_range(60, 140);
            if (len > RANDOM_ITEMS - sent_rand)
                len = RANDOM_ITEMS - sent_rand;
            repeat (len)
            begin
                offer(random_command(insert_pct, phase % 4 == 2));
                sent_rand++;
            end
            phase++;
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("sent %0d commands (directed cases, then %0d random phases); %0d results checked",
                 sent, phase, results_seen);
        $display("list peaked at %0d entries; %0d full refusals, %0d pops on empty",
                 peak_len, full_refusals, empty_pops);
        if (outstanding != 0)
            $display("%0t: %0d results never arrived", $time, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/spd_pkg.sv
sv/spd_cell.sv
sv/spd_ctrl.sv
sv/sorted_priority_deque.sv
dv/spd_order_checker.sv
dv/tb.sv
